// ----- design/bounded_bag_store_macros.svh -----
// ----------------------------------------------------------------------------
// Bounded bag store assertion macros
// Shared concurrent assertion forms for the bag store checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_BAG_STORE_MACROS_SVH
`define BOUNDED_BAG_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded bag store package
// Commands, default sizes and the request and response records.
// ----------------------------------------------------------------------------
package bbs_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W       = 2;
  localparam int ITEM_W      = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [ITEM_W-1:0] item_value;
    cmd_t              command;
  } req_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] size;
    logic [COUNT_OUT_W-1:0] frequency;
    logic                   success;
  } rsp_t;

endpackage

// ----- design/bbs_engine.sv -----
// ----------------------------------------------------------------------------
// Bag store engine
// Entry memory with one comparator that walks the stored entries, and the
// sequencer that applies add, remove, query and clear.
// ----------------------------------------------------------------------------
module bbs_engine #(
  parameter int CAPACITY    = bbs_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  bbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bbs_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_MOVE_RD = 5'b00100,
    S_MOVE_WR = 5'b01000,
    S_RESP    = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  bbs_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       ptr_r, ptr_nxt;
  logic                   pend_r, pend_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]       freq_r, freq_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       match_r, match_nxt;
  logic                   ok_r, ok_nxt;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  logic [63:0]            item_ext;
  logic [CNT_W-1:0]       count_last;
  logic                   scan_more;
  logic                   hit;
  logic [15:0]            freq_ext;
  logic [15:0]            size_ext;

  assign item_ext   = {32'd0, req.item_value};
  assign count_last = count_r - CNT_W'(1);
  assign scan_more  = (ptr_r < count_r);
  assign hit        = pend_r && (rd_data_r == val_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    pend_nxt   = pend_r;
    rd_idx_nxt = rd_idx_r;
    freq_nxt   = freq_r;
    found_nxt  = found_r;
    match_nxt  = match_r;
    ok_nxt     = ok_r;
    mem_re     = 1'b0;
    mem_raddr  = ptr_r[IDX_W-1:0];
    mem_we     = 1'b0;
    mem_waddr  = count_r[IDX_W-1:0];
    mem_wdata  = val_r;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd_nxt   = req.command;
          val_nxt   = item_ext[VALUE_WIDTH-1:0];
          ptr_nxt   = '0;
          pend_nxt  = 1'b0;
          freq_nxt  = '0;
          found_nxt = 1'b0;
          if (req.command == bbs_pkg::CMD_CLEAR) begin
            count_nxt = '0;
            ok_nxt    = 1'b1;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_more) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_r[IDX_W-1:0];
          pend_nxt   = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (hit) begin
          freq_nxt = freq_r + CNT_W'(1);
          if (!found_r) begin
            found_nxt = 1'b1;
            match_nxt = rd_idx_r;
          end
        end
        if (!scan_more && !pend_r) begin
          case (cmd_r)
            bbs_pkg::CMD_ADD: begin
              state_nxt = S_RESP;
              if (count_r < CNT_W'(CAPACITY)) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[IDX_W-1:0];
                mem_wdata = val_r;
                count_nxt = count_r + CNT_W'(1);
                ok_nxt    = 1'b1;
              end else begin
                ok_nxt = 1'b0;
              end
            end
            bbs_pkg::CMD_REMOVE: begin
              if (found_r) begin
                state_nxt = S_MOVE_RD;
              end else begin
                ok_nxt    = 1'b0;
                state_nxt = S_RESP;
              end
            end
            default: begin
              ok_nxt    = found_r;
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_MOVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = count_last[IDX_W-1:0];
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = match_r;
        mem_wdata = rd_data_r;
        count_nxt = count_last;
        ok_nxt    = 1'b1;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    ptr_r    <= ptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    freq_r   <= freq_nxt;
    found_r  <= found_nxt;
    match_r  <= match_nxt;
    ok_r     <= ok_nxt;
  end

  assign freq_ext      = 16'(freq_r);
  assign size_ext      = 16'(count_r);
  assign rsp.success   = ok_r;
  assign rsp.frequency = freq_ext[bbs_pkg::COUNT_OUT_W-1:0];
  assign rsp.size      = size_ext[bbs_pkg::COUNT_OUT_W-1:0];

endmodule

// ----- design/bounded_bag_store.sv -----
// Sequence: a command is compared against every stored entry, then its result passes
// the output register; clear skips the scan, and a remove that hits adds S_MOVE_RD and S_MOVE_WR.
// One command at a time: a new input transfer is taken only once the last result has
// left the engine; the single comparator reads one entry per cycle.
// Reset: synchronous active-low rst_n empties the bag and drops a pending result;
// entry contents are not cleared.
// ----------------------------------------------------------------------------
// Bounded bag store
// Stream-facing top level with an output register in front of the engine.
// ----------------------------------------------------------------------------
module bounded_bag_store #(
  parameter int CAPACITY    = bbs_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bbs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Bits from low: command[1:0], item_value[33:2], zero fill[39:34].
  input  logic [bbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Bits from low: success[0], frequency[5:1], size[10:6], zero fill[15:11].
  output logic [bbs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  bbs_pkg::req_t req;
  bbs_pkg::rsp_t rsp;
  logic          rsp_valid;
  logic          rsp_ready;

  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [bbs_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign req.command    = bbs_pkg::cmd_t'(in_tdata[1:0]);
  assign req.item_value = in_tdata[33:2];

  bbs_engine #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (rsp_ready) begin
      out_tvalid_nxt = rsp_valid;
      if (rsp_valid) begin
        out_tdata_nxt = bbs_pkg::OUT_TDATA_W'(rsp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ----- design/bbs_checker.sv -----
// ----------------------------------------------------------------------------
// Bag store checker
// Port-level assertions on the bag store, bound to its top level.
// ----------------------------------------------------------------------------
`include "bounded_bag_store_macros.svh"

module bbs_checker #(
  parameter int CAPACITY = bbs_pkg::CAPACITY_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bbs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [bbs_pkg::IN_TDATA_W-1:0] in_pad;

  assign in_pad = in_tdata;

  `BBS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `BBS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "new transfer accepted while a command is in progress")
  `BBS_ASSERT_NOW(a_size_bound, out_tvalid, (CAPACITY > 31) || (out_tdata[10:6] <= 5'(CAPACITY)), "reported size exceeds capacity")
  `BBS_ASSERT_NOW(a_freq_bound, out_tvalid && (in_pad[0] || !in_pad[0]), (CAPACITY > 31) || (out_tdata[5:1] <= 5'(CAPACITY)), "reported frequency exceeds capacity")

endmodule

bind bounded_bag_store bbs_checker #(
  .CAPACITY (CAPACITY)
) u_bbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/bounded_bag_store_tb.sv -----
// ----------------------------------------------------------------------------
// Bounded bag store testbench
// Streams add, remove, query and clear commands into the bag under random
// bursts and output stalls. A mirror of the bag predicts every reply, and
// each reply is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_bag_store_tb;

  localparam int CAPACITY    = bbs_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1500;

  class bag_tracker;
    logic [bbs_pkg::ITEM_W-1:0] mirror_entries [CAPACITY];
    int unsigned                mirror_count;
    bbs_pkg::rsp_t              due_replies [$];
    int                         error_count;

    function void report(string msg);
      error_count++;
      if (error_count <= 10) begin
        $display("ERROR: %s", msg);
      end
    endfunction

    function void apply_command(bbs_pkg::req_t r);
      int            freq;
      int            hit;
      bbs_pkg::rsp_t e;
      freq = 0;
      hit = -1;
      e = '0;
      if (r.command != bbs_pkg::CMD_CLEAR) begin
        for (int i = 0; i < mirror_count; i++) begin
          if (mirror_entries[i] == r.item_value) begin
            freq++;
            if (hit < 0) begin
              hit = i;
            end
          end
        end
      end
      case (r.command)
        bbs_pkg::CMD_ADD: begin
          if (mirror_count < CAPACITY) begin
            mirror_entries[mirror_count] = r.item_value;
            mirror_count++;
            e.success = 1'b1;
          end
        end
        bbs_pkg::CMD_REMOVE: begin
          if (hit >= 0) begin
            mirror_count--;
            mirror_entries[hit] = mirror_entries[mirror_count];
            e.success = 1'b1;
          end
        end
        bbs_pkg::CMD_QUERY: begin
          e.success = (freq > 0);
        end
        default: begin
          mirror_count = 0;
          e.success = 1'b1;
        end
      endcase
      e.frequency = freq[bbs_pkg::COUNT_OUT_W-1:0];
      e.size = mirror_count[bbs_pkg::COUNT_OUT_W-1:0];
      due_replies.insert(due_replies.size(), e);
    endfunction

    function void check_reply(bbs_pkg::rsp_t got);
      bbs_pkg::rsp_t want;
      if (due_replies.size() == 0) begin
        report($sformatf("unexpected reply success=%0d frequency=%0d size=%0d",
                         got.success, got.frequency, got.size));
        return;
      end
      want = due_replies.pop_front();
      if (got.success !== want.success || got.frequency !== want.frequency ||
          got.size !== want.size) begin
        report($sformatf("reply mismatch: success %0d/%0d frequency %0d/%0d size %0d/%0d",
                         want.success, got.success, want.frequency, got.frequency,
                         want.size, got.size));
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bbs_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bbs_pkg::OUT_TDATA_W-1:0] out_tdata;

  bag_tracker tracker = new();
  int         cycle_count = 0;
  int         burst_left = 0;
  logic [bbs_pkg::ITEM_W-1:0] value_pool [6];

  bounded_bag_store DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_reply(bbs_pkg::rsp_t'(out_tdata[$bits(bbs_pkg::rsp_t)-1:0]));
    end
  end

  initial begin
    int         mode_left;
    int         mode;
    logic [7:0] pattern;
    out_tready = 1'b0;
    mode_left = 0;
    mode = 0;
    pattern = 8'h01;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
        pattern = 8'($urandom) | 8'h01;
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 99) >= 35);
        default: begin
          out_tready <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
      endcase
    end
  end

  task automatic push_item(bbs_pkg::cmd_t cmd, logic [bbs_pkg::ITEM_W-1:0] value);
    bbs_pkg::req_t r;
    r.command = cmd;
    r.item_value = value;
    in_tvalid <= 1'b1;
    in_tdata <= bbs_pkg::IN_TDATA_W'(r);
    do @(posedge clk); while (!in_tready);
    tracker.apply_command(r);
    @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.due_replies.size() != 0);
  endtask

  function automatic logic [bbs_pkg::ITEM_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) begin
      return bbs_pkg::ITEM_W'($urandom);
    end
    return value_pool[$urandom_range(0, 5)];
  endfunction

  function automatic bbs_pkg::cmd_t pick_command(bit add_heavy);
    int roll;
    roll = $urandom_range(0, 99);
    if (add_heavy) begin
      if (roll < 60) return bbs_pkg::CMD_ADD;
      if (roll < 80) return bbs_pkg::CMD_REMOVE;
      if (roll < 98) return bbs_pkg::CMD_QUERY;
      return bbs_pkg::CMD_CLEAR;
    end
    if (roll < 25) return bbs_pkg::CMD_ADD;
    if (roll < 72) return bbs_pkg::CMD_REMOVE;
    if (roll < 96) return bbs_pkg::CMD_QUERY;
    return bbs_pkg::CMD_CLEAR;
  endfunction

  initial begin
    bit add_heavy;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 6; i++) begin
      value_pool[i] = bbs_pkg::ITEM_W'($urandom);
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty bag, extreme values, swap-in on remove, full bag and clear.
    push_item(bbs_pkg::CMD_QUERY, '0);
    push_item(bbs_pkg::CMD_REMOVE, 32'h0000_0007);
    push_item(bbs_pkg::CMD_ADD, '0);
    push_item(bbs_pkg::CMD_ADD, '1);
    push_item(bbs_pkg::CMD_ADD, '0);
    push_item(bbs_pkg::CMD_REMOVE, '0);
    push_item(bbs_pkg::CMD_QUERY, '1);
    push_item(bbs_pkg::CMD_CLEAR, bbs_pkg::ITEM_W'($urandom));
    for (int i = 0; i < CAPACITY; i++) begin
      push_item(bbs_pkg::CMD_ADD, 32'h8000_0001);
    end
    push_item(bbs_pkg::CMD_ADD, 32'h1234_5678);
    push_item(bbs_pkg::CMD_QUERY, 32'h8000_0001);
    push_item(bbs_pkg::CMD_REMOVE, 32'h1234_5678);
    push_item(bbs_pkg::CMD_REMOVE, 32'h8000_0001);
    push_item(bbs_pkg::CMD_CLEAR, '1);
    drain();

    add_heavy = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        add_heavy = 1'($urandom_range(0, 1));
      end
      if (n % 40 == 0) begin
        value_pool[$urandom_range(2, 5)] = bbs_pkg::ITEM_W'($urandom);
      end
      if (n % 300 == 150) begin
        drain();
      end
      pace();
      push_item(pick_command(add_heavy), pick_value());
    end

    drain();
    repeat (CAPACITY + 10) @(negedge clk);
    if (tracker.due_replies.size() != 0) begin
      tracker.report($sformatf("%0d replies never arrived", tracker.due_replies.size()));
    end
    if (tracker.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
